@@ src/egar_pkg.sv @@
package egar_pkg;

    localparam int SAMPLE_W = 16;
    localparam int ADDR_W   = 15;
    localparam int THRESH_W = 14;
    localparam int LIMIT_W  = 8;
    localparam int SKIP_W   = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(40);
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(45);
    localparam logic [SKIP_W-1:0]   SKIP_RESET   = SKIP_W'(768);
    localparam logic [LIMIT_W-1:0]  RUN_MAX      = {LIMIT_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NOISE_THRESHOLD = 2'd0,
        REG_SILENCE_LIMIT   = 2'd1,
        REG_SKIP_SAMPLES    = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        FUNC_START  = 1'b0,
        FUNC_SAMPLE = 1'b1
    } func_t;

    typedef enum logic {
        STOP_SILENCE = 1'b0,
        STOP_BUFFER  = 1'b1
    } stop_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] silence_limit;
        logic [SKIP_W-1:0]  skip_samples;
    } cfg_t;

    typedef struct packed {
        logic                       write_enable;
        logic [ADDR_W-1:0]          write_address;
        logic signed [SAMPLE_W-1:0] write_data;
        logic                       frame_end;
        logic                       frame_silent;
        logic                       done_res;
        logic                       stop_reason;
        logic                       recording;
    } res_t;

endpackage

@@ src/egar_in_if.sv @@
interface egar_in_if import egar_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output func, output sample, input ready);
    modport sink   (input valid, input func, input sample, output ready);
endinterface

@@ src/egar_out_if.sv @@
interface egar_out_if import egar_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic                       write_enable;
    logic [ADDR_W-1:0]          write_address;
    logic signed [SAMPLE_W-1:0] write_data;
    logic                       frame_end;
    logic                       frame_silent;
    logic                       done_res;
    logic                       stop_reason;
    logic                       recording;

    modport source (
        output valid, output write_enable, output write_address, output write_data,
        output frame_end, output frame_silent, output done_res, output stop_reason,
        output recording, input ready
    );
    modport sink (
        input valid, input write_enable, input write_address, input write_data,
        input frame_end, input frame_silent, input done_res, input stop_reason,
        input recording, output ready
    );
endinterface

@@ src/egar_cfg.sv @@
module egar_cfg import egar_pkg::*; #(
    parameter int FRAME_LEN = 128,
    parameter int BND_W     = THRESH_W + 1 + $clog2(4 * FRAME_LEN)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg,
    output logic [BND_W-1:0]      sil_bound
);

    // silent when sum < (threshold + 1) * 4 * FRAME_LEN, i.e. sum / (4*FRAME_LEN) <= threshold
    localparam logic [BND_W-1:0] FRAME_DIV   = BND_W'(4 * FRAME_LEN);
    localparam logic [BND_W-1:0] BOUND_RESET = BND_W'((int'(THRESH_RESET) + 1) * 4 * FRAME_LEN);

    logic [BND_W-1:0]   bound_reg, bound_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [SKIP_W-1:0]  skip_reg,  skip_next;

    always_comb
    begin
        bound_next = bound_reg;
        limit_next = limit_reg;
        skip_next  = skip_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_NOISE_THRESHOLD:
                    bound_next = BND_W'((BND_W'(cfg_data[THRESH_W-1:0]) + BND_W'(1)) * FRAME_DIV);
                REG_SILENCE_LIMIT:
                    limit_next = cfg_data[LIMIT_W-1:0];
                REG_SKIP_SAMPLES:
                    skip_next  = cfg_data[SKIP_W-1:0];
                default:
                    bound_next = bound_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg <= BOUND_RESET;
            limit_reg <= LIMIT_RESET;
            skip_reg  <= SKIP_RESET;
        end
        else
        begin
            bound_reg <= bound_next;
            limit_reg <= limit_next;
            skip_reg  <= skip_next;
        end
    end

    assign cfg.silence_limit = limit_reg;
    assign cfg.skip_samples  = skip_reg;
    assign sil_bound         = bound_reg;

endmodule

@@ src/egar_core.sv @@
module egar_core import egar_pkg::*; #(
    parameter int FRAME_LEN      = 128,
    parameter int BUFFER_SAMPLES = 32767,
    parameter int BND_W          = THRESH_W + 1 + $clog2(4 * FRAME_LEN)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       acc,
    input  logic                       func,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  cfg_t                       cfg,
    input  logic [BND_W-1:0]           sil_bound,
    output res_t                       res
);

    localparam int POS_W = $clog2(FRAME_LEN);
    localparam int SUM_W = SAMPLE_W + $clog2(FRAME_LEN);
    localparam int CNT_W = $clog2(BUFFER_SAMPLES + 1);
    localparam int DIF_W = (CNT_W > ADDR_W) ? CNT_W : ADDR_W;
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_LEN - 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(BUFFER_SAMPLES);

    logic               active_reg, active_next;
    logic [POS_W-1:0]   pos_reg,    pos_next;
    logic [SUM_W-1:0]   sum_reg,    sum_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic [LIMIT_W-1:0] run_reg,    run_next;

    logic [SAMPLE_W-1:0] mag;
    logic [SUM_W-1:0]    sum_add;
    logic [CNT_W-1:0]    cnt_inc;
    logic [DIF_W-1:0]    addr_dif;
    logic [LIMIT_W-1:0]  run_inc;
    logic                last;
    logic                silent;

    // magnitude of the most negative sample still fits 16 bits unsigned
    assign mag      = sample[SAMPLE_W-1] ? (~sample + SAMPLE_W'(1)) : sample;
    assign sum_add  = sum_reg + SUM_W'(mag);
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign addr_dif = DIF_W'(cnt_reg) - DIF_W'(cfg.skip_samples);
    assign run_inc  = (run_reg == RUN_MAX) ? RUN_MAX : run_reg + LIMIT_W'(1);
    assign last     = (pos_reg == POS_LAST);
    assign silent   = (BND_W'(sum_add) < sil_bound);

    always_comb
    begin
        active_next = active_reg;
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        run_next    = run_reg;
        res         = '0;
        if (acc)
        begin
            if (func == FUNC_START)
            begin
                active_next = 1'b1;
                pos_next    = '0;
                sum_next    = '0;
                cnt_next    = '0;
                run_next    = '0;
            end
            else if (active_reg)
            begin
                if (DIF_W'(cnt_reg) >= DIF_W'(cfg.skip_samples))
                begin
                    res.write_enable  = 1'b1;
                    res.write_address = addr_dif[ADDR_W-1:0];
                    res.write_data    = sample;
                end
                cnt_next = cnt_inc;
                if (last)
                begin
                    res.frame_end = 1'b1;
                    pos_next      = '0;
                    sum_next      = '0;
                    if (silent)
                    begin
                        res.frame_silent = 1'b1;
                        run_next         = run_inc;
                        if (run_inc >= cfg.silence_limit)
                        begin
                            run_next     = '0;
                            res.done_res = 1'b1;
                        end
                    end
                    else
                    begin
                        run_next = '0;
                    end
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                    sum_next = sum_add;
                end
                // silence stop takes precedence over buffer full
                if (!res.done_res && (cnt_inc >= CNT_LIMIT))
                begin
                    res.done_res    = 1'b1;
                    res.stop_reason = STOP_BUFFER;
                end
                active_next = !res.done_res;
            end
        end
        res.recording = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pos_reg    <= '0;
            sum_reg    <= '0;
            cnt_reg    <= '0;
            run_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            cnt_reg    <= cnt_next;
            run_reg    <= run_next;
        end
    end

    a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
        res.done_res |=> !active_reg)
        else $error("recording still active after a stop");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && func == FUNC_START) |=> (active_reg && cnt_reg == '0 && pos_reg == '0))
        else $error("start did not clear the counters");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("frame position beyond frame length");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!active_reg && !(acc && func == FUNC_START)) |=> ($stable(cnt_reg) && !active_reg))
        else $error("counters moved while idle");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (cnt_reg < CNT_LIMIT))
        else $error("sample count reached buffer limit while recording");

endmodule

@@ src/egar_out.sv @@
module egar_out import egar_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    output logic up_ready,
    input  res_t up_res,
    egar_out_if.source results
);

    logic valid_reg, valid_next;
    res_t res_reg;

    assign up_ready   = !valid_reg || results.ready;
    assign valid_next = up_valid || (valid_reg && !results.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            res_reg <= up_res;
        end
    end

    assign results.valid         = valid_reg;
    assign results.write_enable  = res_reg.write_enable;
    assign results.write_address = res_reg.write_address;
    assign results.write_data    = res_reg.write_data;
    assign results.frame_end     = res_reg.frame_end;
    assign results.frame_silent  = res_reg.frame_silent;
    assign results.done_res      = res_reg.done_res;
    assign results.stop_reason   = res_reg.stop_reason;
    assign results.recording     = res_reg.recording;

endmodule

@@ src/energy_gated_audio_recorder.sv @@
// Channel   | Dir | Payload                                        | Handshake
// ----------+-----+------------------------------------------------+------------------
// samples   | in  | func, sample                                   | valid / ready
// results   | out | write_enable .. recording (one per request)    | valid / ready
// cfg       | in  | cfg_index, cfg_data                            | cfg_write strobe
//
// Every request gives exactly one result, in the cycle after acceptance.
// Sustained rate one request per clock while results.ready is high: the
// recorder state updates at the accepting edge and the result lands in the output register.
// Reset (rst_n, async, active low) stops recording and loads the register
// defaults: threshold 40, silence limit 45, skip 768.
// samples.ready drops only while the output register holds a result that
// results.ready has not taken; there is no other stall.
module energy_gated_audio_recorder import egar_pkg::*; #(
    parameter int FRAME_LEN      = 128,
    parameter int BUFFER_SAMPLES = 32767
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    egar_in_if.sink               samples,
    egar_out_if.source            results
);

    // width of the silence bound: (max threshold + 1) * 4 * FRAME_LEN
    localparam int BND_W = THRESH_W + 1 + $clog2(4 * FRAME_LEN);

    cfg_t             cfg;
    logic [BND_W-1:0] sil_bound;
    res_t             res;
    logic             acc;
    logic             up_ready;

    // register file; the threshold is kept pre-scaled as a sum bound
    egar_cfg #(
        .FRAME_LEN (FRAME_LEN),
        .BND_W     (BND_W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .sil_bound (sil_bound)
    );

    assign samples.ready = up_ready;
    assign acc           = samples.valid && up_ready;

    // counters, frame energy and stop decisions
    egar_core #(
        .FRAME_LEN      (FRAME_LEN),
        .BUFFER_SAMPLES (BUFFER_SAMPLES),
        .BND_W          (BND_W)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .func      (samples.func),
        .sample    (samples.sample),
        .cfg       (cfg),
        .sil_bound (sil_bound),
        .res       (res)
    );

    // output register, decouples samples.ready from a stalled sink
    egar_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (samples.valid),
        .up_ready (up_ready),
        .up_res   (res),
        .results  (results)
    );

endmodule
